>>> design/sht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sht_pkg
// Shared types and constants for the two-wire humidity sensor master.
// ----------------------------------------------------------------------------
package sht_pkg;

    localparam int RESET_PULSES = 10;

    localparam int HALF_W  = 8;
    localparam int POLL_IW = 24;
    localparam int RETRY_W = 10;
    localparam int CFG_W   = 24;
    localparam int CFG_IW  = 2;
    localparam int WORD_W  = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [HALF_W-1:0]  HALF_RESET  = 8'd8;
    localparam logic [POLL_IW-1:0] POLL_RESET  = 24'd24000;
    localparam logic [RETRY_W-1:0] RETRY_RESET = 10'd350;

    localparam logic [CFG_IW-1:0] CFG_HALF_PERIOD   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_POLL_INTERVAL = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_RETRY_LIMIT   = 2'd2;

    typedef enum logic [1:0] {
        OP_SEND  = 2'd0,
        OP_READ  = 2'd1,
        OP_WAIT  = 2'd2,
        OP_RESET = 2'd3
    } t_op;

    // One classified tick as it travels from the front end to the sequencer.
    typedef struct packed {
        logic       start;
        t_op        op;
        logic [7:0] init_shift;
        logic       din;
    } t_tick_item;

    typedef struct packed {
        logic sclk;
        logic data_drive;
        logic data_level;
        logic busy;
        logic done;
        logic status;
        logic [WORD_W-1:0] read_value;
    } t_result;

endpackage

>>> design/sht_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sht_front
// Input side: takes tick items and classifies the command request carried
// with each one before it is queued.
// ----------------------------------------------------------------------------
module sht_front (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_start_req,
    input  logic [1:0]            i_operation,
    input  logic [7:0]            i_cmd_byte,
    input  logic                  i_data_in,
    input  logic                  i_queue_full,
    output logic                  o_push,
    output sht_pkg::t_tick_item   o_item
);

    sht_pkg::t_op w_op;

    assign w_op    = sht_pkg::t_op'(i_operation);
    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        o_item.start      = i_start_req;
        o_item.op         = w_op;
        // Only a send command loads its byte into the shifter.
        o_item.init_shift = (w_op == sht_pkg::OP_SEND) ? i_cmd_byte : 8'd0;
        o_item.din        = i_data_in;
    end

endmodule

>>> design/sht_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sht_queue
// Short FIFO of classified tick items between the front end and the
// pin sequencer.
// ----------------------------------------------------------------------------
module sht_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sht_pkg::t_tick_item   i_item,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output sht_pkg::t_tick_item   o_item
);

    sht_pkg::t_tick_item r_mem [sht_pkg::QUEUE_DEPTH];
    logic [sht_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [sht_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [sht_pkg::QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (sht_pkg::QUEUE_AW+1)'(sht_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> design/sht_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sht_back
// Pin sequencer: advances the bus state by one tick for each queued item
// and registers the pin levels and command status for that tick.
// ----------------------------------------------------------------------------
module sht_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sht_pkg::CFG_IW-1:0]    i_cfg_idx,
    input  logic [sht_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_queue_empty,
    input  sht_pkg::t_tick_item           i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output sht_pkg::t_result              o_result
);

    typedef enum logic [4:0] {
        PH_IDLE  = 5'd0,
        PH_S_PRE = 5'd1,
        PH_S_ST1 = 5'd2,
        PH_S_ST2 = 5'd3,
        PH_S_ST3 = 5'd4,
        PH_S_ST4 = 5'd5,
        PH_S_ST5 = 5'd6,
        PH_S_ST6 = 5'd7,
        PH_S_BV  = 5'd8,
        PH_S_BS  = 5'd9,
        PH_S_BH  = 5'd10,
        PH_S_AR  = 5'd11,
        PH_S_AH  = 5'd12,
        PH_S_AL  = 5'd13,
        PH_R_H   = 5'd14,
        PH_R_L   = 5'd15,
        PH_R_A1  = 5'd16,
        PH_R_A2  = 5'd17,
        PH_R_A3  = 5'd18,
        PH_R_A4  = 5'd19,
        PH_W_CHK = 5'd20,
        PH_W_DLY = 5'd21,
        PH_X_H   = 5'd22,
        PH_X_L   = 5'd23
    } t_phase;

    // Configuration registers.
    logic [sht_pkg::HALF_W-1:0]  r_half;
    logic [sht_pkg::POLL_IW-1:0] r_poll_ivl;
    logic [sht_pkg::RETRY_W-1:0] r_retry;

    // Sequencer state.
    t_phase                       r_phase,  n_phase;
    sht_pkg::t_op                 r_op,     n_op;
    logic [3:0]                   r_bit,    n_bit;
    logic [sht_pkg::WORD_W-1:0]   r_shift,  n_shift;
    logic [sht_pkg::POLL_IW-1:0]  r_tick,   n_tick;
    logic [sht_pkg::RETRY_W-1:0]  r_poll,   n_poll;
    logic                         r_status;

    logic                         r_out_valid;
    sht_pkg::t_result             r_result, n_result;

    // Working values after a possible command start.
    t_phase                       w_phase;
    sht_pkg::t_op                 w_op;
    logic [3:0]                   w_bit;
    logic [sht_pkg::WORD_W-1:0]   w_shift;
    logic [sht_pkg::POLL_IW-1:0]  w_tick;
    logic [sht_pkg::RETRY_W-1:0]  w_poll;
    logic                         w_status;
    logic                         w_status_adv;
    logic                         w_busy;
    logic [sht_pkg::POLL_IW-1:0]  w_dur_m1;
    logic                         w_seg_end;
    logic                         w_done;
    logic [sht_pkg::RETRY_W-1:0]  w_poll_inc;
    logic [2:0]                   w_prev_idx;
    logic                         w_cur_bit;
    logic                         w_prev_bit;
    logic                         w_ack;

    assign o_pop    = !i_queue_empty && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    always_comb begin
        w_phase  = r_phase;
        w_op     = r_op;
        w_bit    = r_bit;
        w_shift  = r_shift;
        w_tick   = r_tick;
        w_poll   = r_poll;
        w_status = r_status;
        if (r_phase == PH_IDLE && i_item.start) begin
            w_op     = i_item.op;
            w_bit    = 4'd0;
            w_shift  = {8'd0, i_item.init_shift};
            w_tick   = '0;
            w_poll   = '0;
            w_status = 1'b0;
            unique case (i_item.op)
                sht_pkg::OP_SEND:  w_phase = PH_S_PRE;
                sht_pkg::OP_READ:  w_phase = PH_R_H;
                sht_pkg::OP_WAIT:  w_phase = PH_W_CHK;
                sht_pkg::OP_RESET: w_phase = PH_X_H;
                default:           w_phase = PH_IDLE;
            endcase
        end
    end

    assign w_busy     = (w_phase != PH_IDLE);
    assign w_prev_idx = 3'(w_bit - 4'd1);
    assign w_cur_bit  = w_shift[3'd7 - w_bit[2:0]];
    assign w_prev_bit = w_shift[3'd7 - w_prev_idx];
    assign w_ack      = (w_bit == 4'd0);
    assign w_poll_inc = w_poll + 1'b1;

    // A segment of zero length counts as one tick.
    always_comb begin
        priority if (w_phase == PH_W_CHK) begin
            w_dur_m1 = '0;
        end else if (w_phase == PH_W_DLY) begin
            w_dur_m1 = (r_poll_ivl == '0) ? '0 : r_poll_ivl - 1'b1;
        end else begin
            w_dur_m1 = (r_half == '0) ? '0
                     : {{(sht_pkg::POLL_IW-sht_pkg::HALF_W){1'b0}}, r_half - 1'b1};
        end
    end

    assign w_seg_end = w_busy && !(w_tick < w_dur_m1);

    // Pin levels for this tick.
    always_comb begin
        n_result            = '0;
        n_result.data_level = 1'b1;
        n_result.busy       = w_busy;
        unique case (w_phase)
            PH_S_PRE: n_result.data_drive = 1'b1;
            PH_S_ST1: begin
                n_result.sclk       = 1'b1;
                n_result.data_drive = 1'b1;
            end
            PH_S_ST2: begin
                n_result.sclk       = 1'b1;
                n_result.data_drive = 1'b1;
                n_result.data_level = 1'b0;
            end
            PH_S_ST3: begin
                n_result.data_drive = 1'b1;
                n_result.data_level = 1'b0;
            end
            PH_S_ST4: begin
                n_result.sclk       = 1'b1;
                n_result.data_drive = 1'b1;
                n_result.data_level = 1'b0;
            end
            PH_S_ST5: begin
                n_result.sclk       = 1'b1;
                n_result.data_drive = 1'b1;
            end
            PH_S_ST6: n_result.data_drive = 1'b1;
            PH_S_BV: begin
                // The previous bit is held while the clock is low; before the first bit, data is driven low.
                n_result.data_drive = 1'b1;
                n_result.data_level = (w_bit == 4'd0) ? 1'b0 : w_prev_bit;
            end
            PH_S_BS: begin
                n_result.data_drive = 1'b1;
                n_result.data_level = w_cur_bit;
            end
            PH_S_BH: begin
                n_result.sclk       = 1'b1;
                n_result.data_drive = 1'b1;
                n_result.data_level = w_cur_bit;
            end
            PH_S_AH: n_result.sclk = 1'b1;
            PH_R_H:  n_result.sclk = 1'b1;
            PH_R_A1: n_result.data_drive = 1'b1;
            PH_R_A2: begin
                n_result.data_drive = 1'b1;
                n_result.data_level = w_ack;
            end
            PH_R_A3: begin
                n_result.sclk       = 1'b1;
                n_result.data_drive = 1'b1;
                n_result.data_level = w_ack;
            end
            PH_X_H:  n_result.sclk = 1'b1;
            default: n_result.sclk = 1'b0;
        endcase
        n_result.done = w_done;
        if (w_done) begin
            n_result.status = (w_op == sht_pkg::OP_SEND || w_op == sht_pkg::OP_WAIT)
                            ? w_status_adv : 1'b0;
            n_result.read_value = (w_op == sht_pkg::OP_READ) ? n_shift : '0;
        end
    end

    // Count ticks within a segment; at segment end, move to the next phase.
    always_comb begin
        n_phase      = w_phase;
        n_op         = w_op;
        n_bit        = w_bit;
        n_shift      = w_shift;
        n_tick       = w_tick;
        n_poll       = w_poll;
        w_status_adv = w_status;
        w_done       = 1'b0;
        if (w_busy) begin
            if (!w_seg_end) begin
                n_tick = w_tick + 1'b1;
            end else begin
                n_tick = '0;
                unique case (w_phase)
                    PH_S_PRE: n_phase = PH_S_ST1;
                    PH_S_ST1: n_phase = PH_S_ST2;
                    PH_S_ST2: n_phase = PH_S_ST3;
                    PH_S_ST3: n_phase = PH_S_ST4;
                    PH_S_ST4: n_phase = PH_S_ST5;
                    PH_S_ST5: n_phase = PH_S_ST6;
                    PH_S_ST6: n_phase = PH_S_BV;
                    PH_S_BV:  n_phase = PH_S_BS;
                    PH_S_BS:  n_phase = PH_S_BH;
                    PH_S_BH: begin
                        if (w_bit >= 4'd7) begin
                            n_phase = PH_S_AR;
                        end else begin
                            n_bit   = w_bit + 4'd1;
                            n_phase = PH_S_BV;
                        end
                    end
                    PH_S_AR:  n_phase = PH_S_AH;
                    PH_S_AH: begin
                        w_status_adv = i_item.din;
                        n_phase      = PH_S_AL;
                    end
                    PH_S_AL:  w_done = 1'b1;
                    PH_R_H: begin
                        n_shift = {w_shift[sht_pkg::WORD_W-2:0], i_item.din};
                        n_phase = PH_R_L;
                    end
                    PH_R_L: begin
                        n_phase = (w_bit[2:0] == 3'd7) ? PH_R_A1 : PH_R_H;
                        n_bit   = w_bit + 4'd1;
                    end
                    PH_R_A1:  n_phase = PH_R_A2;
                    PH_R_A2:  n_phase = PH_R_A3;
                    PH_R_A3:  n_phase = PH_R_A4;
                    PH_R_A4: begin
                        // The bit counter wraps to zero after the second byte.
                        if (w_bit == 4'd0) begin
                            w_done = 1'b1;
                        end else begin
                            n_phase = PH_R_H;
                        end
                    end
                    PH_W_CHK: begin
                        priority if (w_poll >= r_retry) begin
                            w_status_adv = 1'b0;
                            w_done       = 1'b1;
                        end else if (!i_item.din) begin
                            w_status_adv = 1'b1;
                            w_done       = 1'b1;
                        end else begin
                            n_phase = PH_W_DLY;
                        end
                    end
                    PH_W_DLY: begin
                        n_poll  = w_poll_inc;
                        n_phase = PH_W_CHK;
                    end
                    PH_X_H:   n_phase = PH_X_L;
                    PH_X_L: begin
                        n_poll = w_poll_inc;
                        if (w_poll_inc >= sht_pkg::RETRY_W'(sht_pkg::RESET_PULSES)) begin
                            w_done = 1'b1;
                        end else begin
                            n_phase = PH_X_H;
                        end
                    end
                    default:  w_done = 1'b1;
                endcase
                if (w_done) begin
                    n_phase = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= sht_pkg::HALF_RESET;
            r_poll_ivl  <= sht_pkg::POLL_RESET;
            r_retry     <= sht_pkg::RETRY_RESET;
            r_phase     <= PH_IDLE;
            r_op        <= sht_pkg::OP_SEND;
            r_bit       <= '0;
            r_shift     <= '0;
            r_tick      <= '0;
            r_poll      <= '0;
            r_status    <= 1'b0;
            r_out_valid <= 1'b0;
            r_result    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sht_pkg::CFG_HALF_PERIOD:
                        r_half <= i_cfg_data[sht_pkg::HALF_W-1:0];
                    sht_pkg::CFG_POLL_INTERVAL:
                        r_poll_ivl <= i_cfg_data[sht_pkg::POLL_IW-1:0];
                    sht_pkg::CFG_RETRY_LIMIT:
                        r_retry <= i_cfg_data[sht_pkg::RETRY_W-1:0];
                    default: r_half <= r_half;
                endcase
            end
            if (o_pop) begin
                r_phase  <= n_phase;
                r_op     <= n_op;
                r_bit    <= n_bit;
                r_shift  <= n_shift;
                r_tick   <= n_tick;
                r_poll   <= n_poll;
                r_status <= w_status_adv;
                r_result <= n_result;
            end
            r_out_valid <= o_pop || (r_out_valid && !i_ready);
        end
    end

endmodule

>>> design/two_wire_humidity_sensor_master_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_wire_humidity_sensor_master_unit
// Tick-driven master for a two-wire humidity and temperature sensor bus.
// ----------------------------------------------------------------------------
// Each accepted item is one timing tick and yields exactly one result item
// with the clock and data pin levels for that tick and the command status.
// One item is taken per clock cycle while the input queue is not full. An
// accepted item is written into the input queue; when it reaches the head
// and no earlier result is still waiting, the sequencer registers its result.
// The four-entry queue lets the input side keep accepting while a result
// waits to be taken. Configuration registers (half period, poll interval,
// retry limit) are written through the plain write port and take effect on
// the next tick processed.
module two_wire_humidity_sensor_master_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_start_req,
    input  logic [1:0]                 i_operation,
    input  logic [7:0]                 i_cmd_byte,
    input  logic                       i_data_in,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_sclk,
    output logic                       o_data_drive,
    output logic                       o_data_level,
    output logic                       o_busy_res,
    output logic                       o_done_res,
    output logic                       o_status,
    output logic [15:0]                o_read_value,
    input  logic                       i_cfg_we,
    input  logic [sht_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [sht_pkg::CFG_W-1:0]  i_cfg_data
);

    sht_pkg::t_tick_item w_push_item;
    sht_pkg::t_tick_item w_head_item;
    sht_pkg::t_result    w_result;
    logic                w_push;
    logic                w_pop;
    logic                w_full;
    logic                w_empty;

    sht_front u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_start_req  (i_start_req),
        .i_operation  (i_operation),
        .i_cmd_byte   (i_cmd_byte),
        .i_data_in    (i_data_in),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    sht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_head_item)
    );

    sht_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_queue_empty (w_empty),
        .i_item        (w_head_item),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result      (w_result)
    );

    assign o_sclk       = w_result.sclk;
    assign o_data_drive = w_result.data_drive;
    assign o_data_level = w_result.data_level;
    assign o_busy_res   = w_result.busy;
    assign o_done_res   = w_result.done;
    assign o_status     = w_result.status;
    assign o_read_value = w_result.read_value;

endmodule

>>> design/sht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sht_checker
// Port-level checks on the sensor master's result stream.
// ----------------------------------------------------------------------------
module sht_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_sclk,
    input logic        o_data_drive,
    input logic        o_data_level,
    input logic        o_busy_res,
    input logic        o_done_res,
    input logic        o_status,
    input logic [15:0] o_read_value
);

    // A command can only complete while it is in progress.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> o_busy_res)
        else $error("done reported without busy");

    // With no command running the bus is parked: clock low, data released.
    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_busy_res |-> !o_sclk && !o_data_drive && o_data_level)
        else $error("bus not parked while idle");

    // Status and read data are only reported on the completing tick.
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> !o_status && (o_read_value == 16'd0))
        else $error("status or read data outside done");

    // A result that is not taken stays in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_value) && $stable(o_sclk))
        else $error("stalled result changed");

endmodule

bind two_wire_humidity_sensor_master_unit sht_checker u_sht_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_sclk       (o_sclk),
    .o_data_drive (o_data_drive),
    .o_data_level (o_data_level),
    .o_busy_res   (o_busy_res),
    .o_done_res   (o_done_res),
    .o_status     (o_status),
    .o_read_value (o_read_value)
);
